[hdl/rbch_pkg.sv]
// shared types and fixed widths of the ray/box closest-hit block
// no dependencies
package rbch_pkg;

   localparam int COORD_W = 24;   // signed Q16.8 coordinate
   localparam int SIZE_W  = 16;   // unsigned Q8.8 box size
   localparam int SLOT_W  = 6;
   localparam int CFG_W   = 7;
   localparam int EXT_W   = 25;   // far corner, ray direction
   localparam int DIFF_W  = 26;   // corner minus ray start
   localparam int DLT_W   = 17;   // signed edge length
   localparam int OPND_W  = 27;   // multiplier operand
   localparam int PROD_W  = 54;   // multiplier product
   localparam int QUO_W   = 16;   // divider quotient
   localparam int DVS_W   = 25;   // divider divisor and remainder
   localparam int DVD_W   = DVS_W + QUO_W;
   localparam int OFF_W   = 18;   // rounded offset along an edge
   localparam int PNT_W   = 26;   // unsaturated hit point

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

endpackage

[hdl/rbch_if.sv]
// valid/ready channel interfaces: request, response and csr write
// depends on rbch_pkg
interface rbch_req_if #(parameter int KIND_BITS = 8);
   logic                                     valid;
   logic                                     ready;
   rbch_pkg::opcode_type                     opcode;
   logic [rbch_pkg::SLOT_W-1:0]              slot;
   logic signed [rbch_pkg::COORD_W-1:0]      corner_x;
   logic signed [rbch_pkg::COORD_W-1:0]      corner_y;
   logic [rbch_pkg::SIZE_W-1:0]              box_w;
   logic [rbch_pkg::SIZE_W-1:0]              box_h;
   logic [KIND_BITS-1:0]                     kind_bits;
   logic signed [rbch_pkg::COORD_W-1:0]      ray_start_x;
   logic signed [rbch_pkg::COORD_W-1:0]      ray_start_y;
   logic signed [rbch_pkg::COORD_W-1:0]      ray_through_x;
   logic signed [rbch_pkg::COORD_W-1:0]      ray_through_y;
   logic [KIND_BITS-1:0]                     type_mask;

   modport source(output valid, opcode, slot, corner_x, corner_y, box_w, box_h, kind_bits,
                  ray_start_x, ray_start_y, ray_through_x, ray_through_y, type_mask,
                  input ready);
   modport sink(input valid, opcode, slot, corner_x, corner_y, box_w, box_h, kind_bits,
                ray_start_x, ray_start_y, ray_through_x, ray_through_y, type_mask,
                output ready);
endinterface

interface rbch_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic [rbch_pkg::SLOT_W-1:0]         hit_slot;
   logic signed [rbch_pkg::COORD_W-1:0] hit_x;
   logic signed [rbch_pkg::COORD_W-1:0] hit_y;

   modport source(output valid, hit, hit_slot, hit_x, hit_y, input ready);
   modport sink(input valid, hit, hit_slot, hit_x, hit_y, output ready);
endinterface

interface rbch_csr_if;
   logic                       valid;
   logic                       ready;
   logic [rbch_pkg::CFG_W-1:0] active_entries;

   modport source(output valid, active_entries, input ready);
   modport sink(input valid, active_entries, output ready);
endinterface

[hdl/rbch_box_table.sv]
// box table memory: one write port, one registered read port
// depends on rbch_pkg
module rbch_box_table #(
   parameter int MAX_BOXES = 64,
   parameter int KIND_BITS = 8
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(MAX_BOXES)-1:0]        wr_addr,
   input  logic signed [rbch_pkg::COORD_W-1:0] wr_cx,
   input  logic signed [rbch_pkg::COORD_W-1:0] wr_cy,
   input  logic [rbch_pkg::SIZE_W-1:0]         wr_w,
   input  logic [rbch_pkg::SIZE_W-1:0]         wr_h,
   input  logic [KIND_BITS-1:0]                wr_kind,
   input  logic [$clog2(MAX_BOXES)-1:0]        rd_addr,
   output logic signed [rbch_pkg::COORD_W-1:0] rd_cx,
   output logic signed [rbch_pkg::COORD_W-1:0] rd_cy,
   output logic [rbch_pkg::SIZE_W-1:0]         rd_w,
   output logic [rbch_pkg::SIZE_W-1:0]         rd_h,
   output logic [KIND_BITS-1:0]                rd_kind
);

   typedef struct packed {
      logic signed [rbch_pkg::COORD_W-1:0] cx;
      logic signed [rbch_pkg::COORD_W-1:0] cy;
      logic [rbch_pkg::SIZE_W-1:0]         w;
      logic [rbch_pkg::SIZE_W-1:0]         h;
      logic [KIND_BITS-1:0]                kind;
   } entry_type;

   entry_type mem [MAX_BOXES];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= '{cx: wr_cx, cy: wr_cy, w: wr_w, h: wr_h, kind: wr_kind};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_cx   = rd_ff.cx;
   assign rd_cy   = rd_ff.cy;
   assign rd_w    = rd_ff.w;
   assign rd_h    = rd_ff.h;
   assign rd_kind = rd_ff.kind;

endmodule

[hdl/rbch_mul.sv]
// shared signed multiplier with registered product
// depends on rbch_pkg
module rbch_mul (
   input  logic                               clock,
   input  logic signed [rbch_pkg::OPND_W-1:0] opnd_a,
   input  logic signed [rbch_pkg::OPND_W-1:0] opnd_b,
   output logic signed [rbch_pkg::PROD_W-1:0] product
);

   logic signed [rbch_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= rbch_pkg::PROD_W'(opnd_a) * rbch_pkg::PROD_W'(opnd_b);
   end

   assign product = prod_ff;

endmodule

[hdl/rbch_div.sv]
// restoring divider, one quotient bit per cycle
// depends on rbch_pkg; dividend must be below divisor * 2**QUO_W
module rbch_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rbch_pkg::div_cmd_type cmd,
   output rbch_pkg::div_rsp_type rsp
);

   localparam int CNT_W = $clog2(rbch_pkg::QUO_W + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [rbch_pkg::DVS_W-1:0]    rem_ff, rem_in;
   logic [rbch_pkg::DVS_W-1:0]    dvs_ff, dvs_in;
   logic [rbch_pkg::QUO_W-1:0]    dvd_ff, dvd_in;
   logic [rbch_pkg::QUO_W-1:0]    quo_ff, quo_in;
   logic [rbch_pkg::DVS_W:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, dvd_ff[rbch_pkg::QUO_W-1]};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(rbch_pkg::QUO_W);
         rem_in  = cmd.dividend[rbch_pkg::DVD_W-1:rbch_pkg::QUO_W];
         dvd_in  = cmd.dividend[rbch_pkg::QUO_W-1:0];
         dvs_in  = cmd.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = rbch_pkg::DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[rbch_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[rbch_pkg::DVS_W-1:0];
            quo_in = {quo_ff[rbch_pkg::QUO_W-2:0], 1'b0};
         end
         dvd_in = {dvd_ff[rbch_pkg::QUO_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign rsp = '{done: done_ff, quotient: quo_ff, remainder: rem_ff};

endmodule

[hdl/ray_box_closest_hit_top.sv]
// closest ray hit against a table of axis-aligned boxes, top level
// depends on rbch_pkg, rbch_if, rbch_box_table, rbch_mul, rbch_div
//
// A write transfer (opcode write) stores one box in the table; slots at or
// beyond MAX_BOXES are dropped. A query transfer casts a ray from ray_start
// through ray_through and scans slots 0 .. active_entries-1 (capped at
// MAX_BOXES). Boxes whose kind shares no bit with type_mask are skipped; a
// matching box tests its top, right, bottom and left edges in turn on one shared
// 27x27 multiplier and one radix-2 divider. An edge is rejected early when it is
// parallel, empty or behind the ray start, or after the multiplies when the
// crossing lies off the edge; otherwise the divider yields its 16 quotient
// bits, and the rounded hit point's squared distance is compared. A query ends
// with one response transfer that holds until taken. The block takes no
// request while a query runs. The nearest hit by squared distance wins,
// earlier box and edge first on ties; with no hit the response carries zeros.
// Slots never written read back undefined data. The csr port is ready whenever
// reset is low; both ready outputs are low during reset.
module ray_box_closest_hit_top #(
   parameter int MAX_BOXES = 64,
   parameter int KIND_BITS = 8
) (
   input  logic           clock,
   input  logic           reset,
   rbch_req_if.sink       req_chan,
   rbch_rsp_if.source     rsp_chan,
   rbch_csr_if.sink       csr_chan
);

   localparam int AW = $clog2(MAX_BOXES);
   localparam int CW = $clog2(MAX_BOXES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH, ST_BOX, ST_SIDE, ST_MUL_PA, ST_MUL_BQ, ST_MUL_DQ,
      ST_RANGE, ST_DIV, ST_ROUND, ST_SQ_X, ST_SQ_Y, ST_CMP, ST_RESP
   } state_type;

   // box edges in scan order
   typedef enum logic [1:0] {
      SIDE_TOP, SIDE_RIGHT, SIDE_BOTTOM, SIDE_LEFT
   } side_type;

   state_type state_ff, state_in;
   side_type  side_ff, side_in;

   logic [rbch_pkg::CFG_W-1:0]          active_ff, active_in;
   logic [CW-1:0]                       n_ff, n_in;
   logic [CW-1:0]                       idx_ff, idx_in;

   // query
   logic signed [rbch_pkg::COORD_W-1:0] r1x_ff, r1x_in, r1y_ff, r1y_in;
   logic signed [rbch_pkg::EXT_W-1:0]   drx_ff, drx_in, dry_ff, dry_in;
   logic [KIND_BITS-1:0]                mask_ff, mask_in;

   // current box
   logic signed [rbch_pkg::EXT_W-1:0]   x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [rbch_pkg::SIZE_W-1:0]         w_ff, w_in, h_ff, h_in;

   // current edge
   logic                                horiz_ff, horiz_in;
   logic signed [rbch_pkg::EXT_W-1:0]   sx_ff, sx_in, sy_ff, sy_in;
   logic signed [rbch_pkg::DIFF_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic signed [rbch_pkg::EXT_W-1:0]   p_ff, p_in, q_ff, q_in;
   logic [rbch_pkg::DVS_W-1:0]          qabs_ff, qabs_in;
   logic signed [rbch_pkg::DLT_W-1:0]   dlt_ff, dlt_in;
   logic signed [rbch_pkg::PROD_W-1:0]  acc_ff, acc_in;
   logic signed [rbch_pkg::PROD_W-1:0]  cn_ff, cn_in;
   logic [rbch_pkg::QUO_W-1:0]          quo_ff, quo_in;
   logic [rbch_pkg::DVS_W-1:0]          rem_ff, rem_in;
   logic signed [rbch_pkg::PNT_W-1:0]   px_ff, px_in, py_ff, py_in;

   // best hit so far
   logic                                found_ff, found_in;
   logic [rbch_pkg::PROD_W-1:0]         best_d_ff, best_d_in;
   logic [AW-1:0]                       best_idx_ff, best_idx_in;
   logic signed [rbch_pkg::PNT_W-1:0]   best_x_ff, best_x_in, best_y_ff, best_y_in;

   // response register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_hit_ff, rsp_hit_in;
   logic [rbch_pkg::SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic signed [rbch_pkg::COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // table, multiplier, divider hookup
   logic                                tbl_wr_en;
   logic [AW-1:0]                       tbl_rd_addr;
   logic signed [rbch_pkg::COORD_W-1:0] tbl_cx, tbl_cy;
   logic [rbch_pkg::SIZE_W-1:0]         tbl_w, tbl_h;
   logic [KIND_BITS-1:0]                tbl_kind;
   logic signed [rbch_pkg::OPND_W-1:0]  mul_a, mul_b;
   logic signed [rbch_pkg::PROD_W-1:0]  mul_p;
   rbch_pkg::div_cmd_type               div_cmd;
   rbch_pkg::div_rsp_type               div_rsp;

   // scratch
   logic                                req_xfer;
   logic signed [rbch_pkg::EXT_W-1:0]   t_sx, t_sy;
   logic signed [rbch_pkg::DLT_W-1:0]   t_dlt;
   logic                                t_horiz;
   logic signed [rbch_pkg::DIFF_W-1:0]  t_a, t_b;
   logic signed [rbch_pkg::EXT_W-1:0]   t_p, t_q;
   logic signed [rbch_pkg::PROD_W-1:0]  t_c;
   logic                                t_ok;
   logic [rbch_pkg::PROD_W-1:0]         t_mag;
   logic signed [rbch_pkg::OFF_W-1:0]   t_k, t_off;
   logic [rbch_pkg::DVS_W-1:0]          t_r;
   logic [rbch_pkg::PROD_W-1:0]         t_d;

   rbch_box_table #(.MAX_BOXES(MAX_BOXES), .KIND_BITS(KIND_BITS)) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (AW'(req_chan.slot)),
      .wr_cx   (req_chan.corner_x),
      .wr_cy   (req_chan.corner_y),
      .wr_w    (req_chan.box_w),
      .wr_h    (req_chan.box_h),
      .wr_kind (req_chan.kind_bits),
      .rd_addr (tbl_rd_addr),
      .rd_cx   (tbl_cx),
      .rd_cy   (tbl_cy),
      .rd_w    (tbl_w),
      .rd_h    (tbl_h),
      .rd_kind (tbl_kind)
   );

   rbch_mul u_mul (
      .clock   (clock),
      .opnd_a  (mul_a),
      .opnd_b  (mul_b),
      .product (mul_p)
   );

   rbch_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign req_chan.ready = (state_ff == ST_IDLE) && !reset;
   assign req_xfer      = req_chan.valid && req_chan.ready;
   assign tbl_wr_en     = req_xfer && (req_chan.opcode == rbch_pkg::OP_WRITE)
                          && (32'(req_chan.slot) < MAX_BOXES);
   assign tbl_rd_addr   = idx_ff[AW-1:0];

   assign csr_chan.ready = !reset;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.hit      = rsp_hit_ff;
   assign rsp_chan.hit_slot = rsp_slot_ff;
   assign rsp_chan.hit_x    = rsp_x_ff;
   assign rsp_chan.hit_y    = rsp_y_ff;

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      active_in    = active_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      r1x_in       = r1x_ff;
      r1y_in       = r1y_ff;
      drx_in       = drx_ff;
      dry_in       = dry_ff;
      mask_in      = mask_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      horiz_in     = horiz_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      qabs_in      = qabs_ff;
      dlt_in       = dlt_ff;
      acc_in       = acc_ff;
      cn_in        = cn_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      found_in     = found_ff;
      best_d_in    = best_d_ff;
      best_idx_in  = best_idx_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_cmd      = '0;
      t_sx         = '0;
      t_sy         = '0;
      t_dlt        = '0;
      t_horiz      = 1'b0;
      t_a          = '0;
      t_b          = '0;
      t_p          = '0;
      t_q          = '0;
      t_c          = '0;
      t_ok         = 1'b0;
      t_mag        = '0;
      t_k          = '0;
      t_off        = '0;
      t_r          = '0;
      t_d          = '0;

      if (csr_chan.valid && csr_chan.ready) begin
         active_in = csr_chan.active_entries;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_chan.opcode == rbch_pkg::OP_QUERY)) begin
               r1x_in   = req_chan.ray_start_x;
               r1y_in   = req_chan.ray_start_y;
               drx_in   = rbch_pkg::EXT_W'(req_chan.ray_through_x)
                          - rbch_pkg::EXT_W'(req_chan.ray_start_x);
               dry_in   = rbch_pkg::EXT_W'(req_chan.ray_through_y)
                          - rbch_pkg::EXT_W'(req_chan.ray_start_y);
               mask_in  = req_chan.type_mask;
               n_in     = (32'(active_ff) > MAX_BOXES) ? CW'(MAX_BOXES) : CW'(active_ff);
               idx_in   = '0;
               found_in = 1'b0;
               state_in = ST_FETCH;
            end
         end

         // read address goes out here, data is in the table register next cycle
         ST_FETCH: begin
            if (idx_ff == n_ff) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = found_ff;
               rsp_slot_in  = found_ff ? rbch_pkg::SLOT_W'(best_idx_ff) : '0;
               if (!found_ff) begin
                  rsp_x_in = '0;
                  rsp_y_in = '0;
               end else begin
                  if (best_x_ff > rbch_pkg::PNT_W'(8388607)) begin
                     rsp_x_in = 24'sh7fffff;
                  end else if (best_x_ff < -rbch_pkg::PNT_W'(8388608)) begin
                     rsp_x_in = 24'sh800000;
                  end else begin
                     rsp_x_in = best_x_ff[rbch_pkg::COORD_W-1:0];
                  end
                  if (best_y_ff > rbch_pkg::PNT_W'(8388607)) begin
                     rsp_y_in = 24'sh7fffff;
                  end else if (best_y_ff < -rbch_pkg::PNT_W'(8388608)) begin
                     rsp_y_in = 24'sh800000;
                  end else begin
                     rsp_y_in = best_y_ff[rbch_pkg::COORD_W-1:0];
                  end
               end
               state_in = ST_RESP;
            end else begin
               state_in = ST_BOX;
            end
         end

         ST_BOX: begin
            if ((tbl_kind & mask_ff) == '0) begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_FETCH;
            end else begin
               x0_in    = rbch_pkg::EXT_W'(tbl_cx);
               y0_in    = rbch_pkg::EXT_W'(tbl_cy);
               x1_in    = rbch_pkg::EXT_W'(tbl_cx) + rbch_pkg::EXT_W'({1'b0, tbl_w});
               y1_in    = rbch_pkg::EXT_W'(tbl_cy) + rbch_pkg::EXT_W'({1'b0, tbl_h});
               w_in     = tbl_w;
               h_in     = tbl_h;
               side_in  = SIDE_TOP;
               state_in = ST_SIDE;
            end
         end

         // pick edge start, length and axis; reject parallel, empty or behind
         ST_SIDE: begin
            case (side_ff)
               SIDE_TOP: begin
                  t_horiz = 1'b1; t_sx = x0_ff; t_sy = y0_ff;
                  t_dlt = rbch_pkg::DLT_W'({1'b0, w_ff});
               end
               SIDE_RIGHT: begin
                  t_horiz = 1'b0; t_sx = x1_ff; t_sy = y0_ff;
                  t_dlt = rbch_pkg::DLT_W'({1'b0, h_ff});
               end
               SIDE_BOTTOM: begin
                  t_horiz = 1'b1; t_sx = x1_ff; t_sy = y1_ff;
                  t_dlt = -rbch_pkg::DLT_W'({1'b0, w_ff});
               end
               default: begin
                  t_horiz = 1'b0; t_sx = x0_ff; t_sy = y1_ff;
                  t_dlt = -rbch_pkg::DLT_W'({1'b0, h_ff});
               end
            endcase
            if (t_horiz) begin
               t_a = rbch_pkg::DIFF_W'(t_sy) - rbch_pkg::DIFF_W'(r1y_ff);
               t_b = rbch_pkg::DIFF_W'(t_sx) - rbch_pkg::DIFF_W'(r1x_ff);
               t_p = drx_ff;
               t_q = dry_ff;
            end else begin
               t_a = rbch_pkg::DIFF_W'(t_sx) - rbch_pkg::DIFF_W'(r1x_ff);
               t_b = rbch_pkg::DIFF_W'(t_sy) - rbch_pkg::DIFF_W'(r1y_ff);
               t_p = dry_ff;
               t_q = drx_ff;
            end
            horiz_in = t_horiz;
            sx_in    = t_sx;
            sy_in    = t_sy;
            dlt_in   = t_dlt;
            a_in     = t_a;
            b_in     = t_b;
            p_in     = t_p;
            q_in     = t_q;
            qabs_in  = t_q[rbch_pkg::EXT_W-1] ? rbch_pkg::DVS_W'(-t_q) : rbch_pkg::DVS_W'(t_q);
            if ((t_q == '0) || (t_dlt == '0)
                || ((t_a != '0) && (t_a[rbch_pkg::DIFF_W-1] != t_q[rbch_pkg::EXT_W-1]))) begin
               if (side_ff == SIDE_LEFT) begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_FETCH;
               end else begin
                  side_in  = side_type'(2'(side_ff) + 2'd1);
                  state_in = ST_SIDE;
               end
            end else begin
               state_in = ST_MUL_PA;
            end
         end

         ST_MUL_PA: begin
            mul_a    = rbch_pkg::OPND_W'(p_ff);
            mul_b    = rbch_pkg::OPND_W'(a_ff);
            state_in = ST_MUL_BQ;
         end

         ST_MUL_BQ: begin
            mul_a    = rbch_pkg::OPND_W'(b_ff);
            mul_b    = rbch_pkg::OPND_W'(q_ff);
            acc_in   = mul_p;
            state_in = ST_MUL_DQ;
         end

         // crossing offset times |q|, sign set so the divisor is positive
         ST_MUL_DQ: begin
            t_c      = acc_ff - mul_p;
            cn_in    = q_ff[rbch_pkg::EXT_W-1] ? -t_c : t_c;
            mul_a    = rbch_pkg::OPND_W'(dlt_ff);
            mul_b    = rbch_pkg::OPND_W'({1'b0, qabs_ff});
            state_in = ST_RANGE;
         end

         // crossing must lie within the edge, ends included
         ST_RANGE: begin
            if (dlt_ff[rbch_pkg::DLT_W-1]) begin
               t_ok = (cn_ff[rbch_pkg::PROD_W-1] || (cn_ff == '0)) && (cn_ff >= mul_p);
            end else begin
               t_ok = !cn_ff[rbch_pkg::PROD_W-1] && (cn_ff <= mul_p);
            end
            t_mag = cn_ff[rbch_pkg::PROD_W-1] ? rbch_pkg::PROD_W'(-cn_ff)
                                              : rbch_pkg::PROD_W'(cn_ff);
            if (t_ok) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = t_mag[rbch_pkg::DVD_W-1:0];
               div_cmd.divisor  = qabs_ff;
               state_in         = ST_DIV;
            end else if (side_ff == SIDE_LEFT) begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_FETCH;
            end else begin
               side_in  = side_type'(2'(side_ff) + 2'd1);
               state_in = ST_SIDE;
            end
         end

         ST_DIV: begin
            if (div_rsp.done) begin
               quo_in   = div_rsp.quotient;
               rem_in   = div_rsp.remainder;
               state_in = ST_ROUND;
            end
         end

         // floor quotient, then round half up
         ST_ROUND: begin
            if (!cn_ff[rbch_pkg::PROD_W-1]) begin
               t_k = rbch_pkg::OFF_W'({1'b0, quo_ff});
               t_r = rem_ff;
            end else if (rem_ff == '0) begin
               t_k = -rbch_pkg::OFF_W'({1'b0, quo_ff});
               t_r = '0;
            end else begin
               t_k = -rbch_pkg::OFF_W'({1'b0, quo_ff}) - rbch_pkg::OFF_W'(1);
               t_r = qabs_ff - rem_ff;
            end
            t_off = t_k + (({1'b0, t_r} << 1) >= {1'b0, qabs_ff}
                           ? rbch_pkg::OFF_W'(1) : rbch_pkg::OFF_W'(0));
            if (horiz_ff) begin
               px_in = rbch_pkg::PNT_W'(sx_ff) + rbch_pkg::PNT_W'(t_off);
               py_in = rbch_pkg::PNT_W'(sy_ff);
            end else begin
               px_in = rbch_pkg::PNT_W'(sx_ff);
               py_in = rbch_pkg::PNT_W'(sy_ff) + rbch_pkg::PNT_W'(t_off);
            end
            state_in = ST_SQ_X;
         end

         ST_SQ_X: begin
            mul_a    = rbch_pkg::OPND_W'(px_ff) - rbch_pkg::OPND_W'(r1x_ff);
            mul_b    = mul_a;
            state_in = ST_SQ_Y;
         end

         ST_SQ_Y: begin
            mul_a    = rbch_pkg::OPND_W'(py_ff) - rbch_pkg::OPND_W'(r1y_ff);
            mul_b    = mul_a;
            acc_in   = mul_p;
            state_in = ST_CMP;
         end

         // strict less keeps the earlier box and edge on ties
         ST_CMP: begin
            t_d = rbch_pkg::PROD_W'(acc_ff) + rbch_pkg::PROD_W'(mul_p);
            if (!found_ff || (t_d < best_d_ff)) begin
               found_in    = 1'b1;
               best_d_in   = t_d;
               best_idx_in = idx_ff[AW-1:0];
               best_x_in   = px_ff;
               best_y_in   = py_ff;
            end
            if (side_ff == SIDE_LEFT) begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_FETCH;
            end else begin
               side_in  = side_type'(2'(side_ff) + 2'd1);
               state_in = ST_SIDE;
            end
         end

         ST_RESP: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= SIDE_TOP;
         active_ff    <= '0;
         idx_ff       <= '0;
         n_ff         <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r1x_ff      <= r1x_in;
      r1y_ff      <= r1y_in;
      drx_ff      <= drx_in;
      dry_ff      <= dry_in;
      mask_ff     <= mask_in;
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      horiz_ff    <= horiz_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      qabs_ff     <= qabs_in;
      dlt_ff      <= dlt_in;
      acc_ff      <= acc_in;
      cn_ff       <= cn_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      best_x_ff   <= best_x_in;
      best_y_ff   <= best_y_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
   end

endmodule
